// File: rtl/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared types and constants for the bloom filter add/query block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfiq_pkg;

    localparam int HASH_W       = 64;
    localparam int OAAT_W       = 32;
    localparam int CFG_W        = 13;
    localparam int SEL_W        = 3;
    localparam int MOD_STEP     = 4;
    localparam int MOD_STEPS    = HASH_W / MOD_STEP;
    localparam int MOD_CNT_W    = $clog2(MOD_STEPS);

    localparam logic [HASH_W-1:0] DJB2_SEED = 64'd5381;

    // Register indexes on the configuration port
    localparam logic CFG_FILTER_BYTES = 1'b0;
    localparam logic CFG_HASH_SELECT  = 1'b1;

    // Command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Hash results for one key
    typedef struct packed {
        logic [HASH_W-1:0] djb2;
        logic [OAAT_W-1:0] oaat;
        logic [HASH_W-1:0] mul31;
    } t_hashes;

endpackage

`default_nettype wire

// File: rtl/bfiq_ram.sv
// ----------------------------------------------------------------------------
// bfiq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read one row per cycle, and write it as well when enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// File: rtl/bfiq_hash.sv
// ----------------------------------------------------------------------------
// bfiq_hash
// Iterative hash unit: one key byte per cycle into djb2, one-at-a-time and
// multiply-by-31, then a final one-at-a-time mixing step.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_hash #(
    parameter int KEY_BYTES = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [63:0]              i_key,
    output logic                          o_done,
    output bfiq_pkg::t_hashes             o_hashes
);
    import bfiq_pkg::*;

    localparam int CW = $clog2(KEY_BYTES + 1);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [63:0]       r_key;
    logic [HASH_W-1:0] r_djb2;
    logic [OAAT_W-1:0] r_oaat;
    logic [HASH_W-1:0] r_mul31;
    logic              r_done;

    logic [7:0]        byte_in;
    logic [OAAT_W-1:0] oaat_a, oaat_b, oaat_c;
    logic [OAAT_W-1:0] fin_a, fin_b, fin_c;

    // One byte step and the final mix of the one-at-a-time hash
    always_comb begin
        byte_in = r_key[7:0];
        oaat_a  = r_oaat + OAAT_W'(byte_in);
        oaat_b  = oaat_a + (oaat_a << 10);
        oaat_c  = oaat_b ^ (oaat_b >> 6);
        fin_a   = r_oaat + (r_oaat << 3);
        fin_b   = fin_a ^ (fin_a >> 11);
        fin_c   = fin_b + (fin_b << 15);
    end

    // Step through the key bytes, then mix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(KEY_BYTES)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key   <= i_key;
            r_djb2  <= DJB2_SEED;
            r_oaat  <= '0;
            r_mul31 <= '0;
        end else if (r_busy) begin
            if (r_cnt == CW'(KEY_BYTES)) begin
                r_oaat <= fin_c;
            end else begin
                r_key   <= r_key >> 8;
                r_djb2  <= (r_djb2 << 5) + r_djb2 + HASH_W'(byte_in);
                r_oaat  <= oaat_c;
                r_mul31 <= (r_mul31 << 5) - r_mul31 + HASH_W'(byte_in);
            end
        end
    end

    assign o_done         = r_done;
    assign o_hashes.djb2  = r_djb2;
    assign o_hashes.oaat  = r_oaat;
    assign o_hashes.mul31 = r_mul31;

endmodule

`default_nettype wire

// File: rtl/bfiq_mod.sv
// ----------------------------------------------------------------------------
// bfiq_mod
// Iterative 64-bit modulo by the filter bit count, four dividend bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_mod #(
    parameter int NW = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [bfiq_pkg::HASH_W-1:0] i_dividend,
    input  wire logic [NW-1:0]               i_modulus,
    output logic                             o_done,
    output logic      [NW-1:0]               o_rem
);
    import bfiq_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [HASH_W-1:0]    r_div;
    logic [NW-1:0]        r_mod;
    logic [NW-1:0]        r_rem;
    logic [NW-1:0]        n_rem;
    logic [NW:0]          t;

    // Four restoring steps on the remainder
    always_comb begin
        n_rem = r_rem;
        t     = '0;
        for (int i = 0; i < MOD_STEP; i++) begin
            t = {n_rem, r_div[HASH_W-1-i]};
            if (t >= {1'b0, r_mod}) begin
                t = t - {1'b0, r_mod};
            end
            n_rem = t[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_mod <= i_modulus;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= r_div << MOD_STEP;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: rtl/bloom_filter_insert_query.sv
// Sequence: hashing, then for each enabled hash a modulo reduction, a read of the
//   bit store and a check (query) or write-back (add), then a query raises its result.
// Commands: one at a time, taken only in idle; a result not yet taken holds the
//   next query at its end.
// Reset: a clearing pass over all MAX_FILTER_BYTES bytes zeroes the store, no command taken.
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter with add and query commands on 8-byte keys and up to three
// hashes, each reduced modulo the configured bit count.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_insert_query #(
    parameter int MAX_FILTER_BYTES = 4096,
    parameter int KEY_BYTES        = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic                       i_cfg_idx,
    input  wire logic [bfiq_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_cmd,
    input  wire logic [63:0]                i_key,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_present
);
    import bfiq_pkg::*;

    localparam int FBW = $clog2(MAX_FILTER_BYTES + 1);
    localparam int NW  = FBW + 3;
    localparam int AW  = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_HASH = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_CHK  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state            r_state;
    logic [CFG_W-1:0]  r_fb;
    logic [SEL_W-1:0]  r_hsel;
    logic [AW-1:0]     r_clr;
    logic              r_cmd;
    logic              r_hit;
    logic [SEL_W-1:0]  r_pend;
    logic [NW-1:0]     r_idx;
    t_hashes           r_hashes;
    logic              r_oval;
    logic              r_present;

    logic              in_xfer;
    logic              out_xfer;
    logic              hash_done;
    t_hashes           hashes;
    logic              mod_start;
    logic              mod_done;
    logic [NW-1:0]     mod_rem;
    logic [HASH_W-1:0] mod_a;
    logic [SEL_W-1:0]  pend_src;
    logic [SEL_W-1:0]  pend_left;
    logic [FBW-1:0]    fb_eff;
    logic [NW-1:0]     nbits;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic [2:0]        bit_pos;
    t_hashes           hsrc;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_oval && i_out_ready;

    // Effective bit count: zero reads as one byte, large sizes saturate
    always_comb begin
        if (r_fb == '0) begin
            fb_eff = FBW'(1);
        end else if (32'(r_fb) > 32'(MAX_FILTER_BYTES)) begin
            fb_eff = FBW'(MAX_FILTER_BYTES);
        end else begin
            fb_eff = FBW'(r_fb);
        end
        nbits = {fb_eff, 3'b000};
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb   <= CFG_W'(32);
            r_hsel <= SEL_W'(3);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_FILTER_BYTES: r_fb   <= i_cfg_wdata;
                CFG_HASH_SELECT:  r_hsel <= i_cfg_wdata[SEL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pick the lowest pending hash and start its reduction
    always_comb begin
        pend_src  = (r_state == S_HASH) ? r_hsel : r_pend;
        hsrc      = (r_state == S_HASH) ? hashes : r_hashes;
        pend_left = pend_src;
        mod_a     = hsrc.mul31;
        if (pend_src[0]) begin
            mod_a        = hsrc.djb2;
            pend_left[0] = 1'b0;
        end else if (pend_src[1]) begin
            mod_a        = HASH_W'(hsrc.oaat);
            pend_left[1] = 1'b0;
        end else begin
            pend_left[2] = 1'b0;
        end
        mod_start = ((r_state == S_HASH && hash_done) || r_state == S_CHK)
                    && (pend_src != '0);
    end

    // Bit store port
    always_comb begin
        bit_pos   = r_idx[2:0];
        ram_we    = 1'b0;
        ram_addr  = AW'(r_idx[NW-1:3]);
        ram_wdata = ram_rdata | (8'd1 << bit_pos);
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_addr  = r_clr;
            ram_wdata = '0;
        end else if (r_state == S_CHK && r_cmd == CMD_ADD) begin
            ram_we = 1'b1;
        end
    end

    // Command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_oval  <= 1'b0;
        end else begin
            // Raise a result when the output register is free, drop it on transfer
            if (r_state == S_DONE && r_cmd == CMD_QUERY && (!r_oval || i_out_ready)) begin
                r_oval <= 1'b1;
            end else if (out_xfer) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MAX_FILTER_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_state <= mod_start ? S_MOD : S_DONE;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= mod_start ? S_MOD : S_DONE;
                end
                S_DONE: begin
                    if (r_cmd == CMD_ADD) begin
                        r_state <= S_IDLE;
                    end else if (!r_oval || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

    // Per-command payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= i_cmd;
            r_hit <= 1'b1;
        end
        if (r_state == S_HASH && hash_done) begin
            r_hashes <= hashes;
        end
        if (mod_start) begin
            r_pend <= pend_left;
        end
        if (r_state == S_MOD && mod_done) begin
            r_idx <= mod_rem;
        end
        if (r_state == S_CHK && r_cmd == CMD_QUERY && !ram_rdata[bit_pos]) begin
            r_hit <= 1'b0;
        end
        if (r_state == S_DONE && r_cmd == CMD_QUERY && (!r_oval || i_out_ready)) begin
            r_present <= r_hit;
        end
    end

    bfiq_hash #(
        .KEY_BYTES (KEY_BYTES)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_xfer),
        .i_key    (i_key),
        .o_done   (hash_done),
        .o_hashes (hashes)
    );

    bfiq_mod #(
        .NW (NW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_a),
        .i_modulus  (nbits),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    bfiq_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FILTER_BYTES),
        .AW    (AW)
    ) u_bits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_oval;
    assign o_present   = r_present;

`ifndef SYNTHESIS
    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> r_state == S_HASH)
        else $error("hash result outside hash phase");

    a_mod_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == S_MOD)
        else $error("modulo result outside modulo phase");

    a_write_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != S_CLR) |-> r_cmd == CMD_ADD)
        else $error("bit store written by a query");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> r_idx < nbits)
        else $error("bit index beyond filter size");
`endif

endmodule

`default_nettype wire
